/* rtl/knnrc_pkg.sv */
// Package for the k-nearest-neighbor regression block with a distance cutoff.
// Holds the sizing constants, register codes, payload and control types.
// No dependencies; the controller, datapath, top level and checker import it.
package knnrc_pkg;

  // Table sizing.
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned DIM     = 64;
  localparam int unsigned MAX_K   = 16;

  // Derived widths.
  localparam int unsigned EntIdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EntCntW  = $clog2(ENTRIES + 1);
  localparam int unsigned DimIdxW  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned PosW     = $clog2(DIM + 1);
  localparam int unsigned KW       = $clog2(MAX_K + 1);
  localparam int unsigned SumW     = 33 + KW;
  localparam int unsigned DivCntW  = $clog2(SumW + 1);
  localparam int unsigned VecAddrW = EntIdxW + DimIdxW;
  localparam int unsigned VecDepth = ENTRIES * (2 ** DimIdxW);

  // Configuration registers.
  localparam int unsigned NlW     = 5;
  localparam int unsigned DlW     = 31;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgNeighborLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDistanceLimit = 1'b1;
  localparam logic [NlW-1:0] NlReset = 5'd5;
  localparam logic [DlW-1:0] DlReset = 31'd3277;

  // Request kinds.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] feature_value;
    logic               is_last;
    logic signed [31:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic               is_query_result;
    logic signed [31:0] prediction;
    logic [4:0]         neighbors_used;
    logic               insert_dropped;
    logic [6:0]         table_size;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StQScan,
    StSelInit,
    StSelScan,
    StSelCheck,
    StSelAdd,
    StDivStart,
    StDivRun,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_clr;
    logic scan_query;
    logic scan_run;
    logic sel_init;
    logic sel_take;
    logic sel_add;
    logic div_start;
    logic div_run;
    logic out_load_query;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;
    logic scan_done;
    logic item_last;
    logic k_zero;
    logic k_reached;
    logic sel_stop;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/knnrc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used by the datapath for every table.
module knnrc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port, registered read port; a read of the address being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/knnrc_ctrl.sv */
// Controller state machine of the nearest-neighbor block.
// Depends on knnrc_pkg; drives commands into knnrc_dp and reads its status.
module knnrc_ctrl import knnrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_item_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   stall;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    stall   = 1'b1;
    unique case (state_q)
      StIdle: begin
        // An insert that ends its vector needs the output register right away.
        stall = in_item_i.is_last && (in_item_i.req_type == ReqInsert) &&
                !status_i.out_free;
        if (in_valid_i && !stall) begin
          cmd_o.accept = 1'b1;
          if (in_item_i.req_type == ReqQuery) begin
            if (status_i.scan_needed) begin
              cmd_o.scan_clr   = 1'b1;
              cmd_o.scan_query = 1'b1;
              state_d          = StQScan;
            end else if (in_item_i.is_last) begin
              state_d = StSelInit;
            end
          end
        end
      end
      StQScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = status_i.item_last ? StSelInit : StIdle;
        end
      end
      StSelInit: begin
        cmd_o.sel_init = 1'b1;
        if (status_i.k_zero) begin
          state_d = StDivStart;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = StSelScan;
        end
      end
      StSelScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = StSelCheck;
        end
      end
      StSelCheck: begin
        if (status_i.sel_stop) begin
          state_d = StDivStart;
        end else begin
          cmd_o.sel_take = 1'b1;
          state_d        = StSelAdd;
        end
      end
      StSelAdd: begin
        cmd_o.sel_add = 1'b1;
        if (status_i.k_reached) begin
          state_d = StDivStart;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = StSelScan;
        end
      end
      StDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDivRun;
      end
      StDivRun: begin
        if (status_i.div_done) begin
          state_d = StOut;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load_query = 1'b1;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = stall;

endmodule

/* rtl/knnrc_dp.sv */
// Datapath of the nearest-neighbor block: tables, distance pipeline, selection,
// divider and output register. Depends on knnrc_pkg and knnrc_ram.
module knnrc_dp import knnrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_item_t           in_item_i,
  input  ctrl_cmd_t          cmd_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DlW-1:0]     cfg_data_i,
  input  logic               out_stall_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  output out_item_t          out_item_o
);

  // Configuration and control state.
  logic [NlW-1:0]     nl_q;
  logic [DlW-1:0]     dl_q;
  logic [2*DlW-1:0]   lim_sq_q;
  logic [PosW-1:0]    pos_q;
  logic [EntCntW-1:0] total_q;
  logic               cur_last_q;
  logic [ENTRIES-1:0] dv_q;
  logic [ENTRIES-1:0] picked_q;
  logic [EntCntW-1:0] scan_cnt_q;
  logic               scan_query_q;
  logic               p1_q, a_vld_q, b_vld_q;
  logic               best_vld_q;
  logic [KW-1:0]      k_q, count_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               out_valid_q;

  // Payload registers.
  logic [31:0]         cur_feat_q;
  logic [PosW-1:0]     cur_pos_q;
  logic [EntIdxW-1:0]  p1_idx_q, a_idx_q, b_idx_q, best_idx_q;
  logic [31:0]         a_abs_q;
  logic [63:0]         a_old_q, b_old_q, b_prod_q, best_dist_q;
  logic                a_en_q, b_en_q;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]     quo_q;
  logic [KW-1:0]       rem_q;
  logic                neg_q;
  out_item_t           out_item_q;

  // Memory read data.
  logic [31:0]     vec_rd, tgt_rd;
  logic [PosW-1:0] len_rd;
  logic [63:0]     dist_rd;

  // Item decode.
  logic               acc_ins, acc_ins_last, table_full, pos_lt_dim;
  logic [PosW-1:0]    pos_after;
  logic [EntCntW-1:0] total_next;
  logic               vec_we;

  assign table_full   = (total_q == EntCntW'(ENTRIES));
  assign pos_lt_dim   = (pos_q < PosW'(DIM));
  assign pos_after    = pos_lt_dim ? pos_q + 1'b1 : pos_q;
  assign acc_ins      = cmd_i.accept && (in_item_i.req_type == ReqInsert);
  assign acc_ins_last = acc_ins && in_item_i.is_last;
  assign vec_we       = acc_ins && pos_lt_dim && !table_full;
  assign total_next   = table_full ? total_q : total_q + 1'b1;

  // Scan issue over stored entries.
  logic               issue;
  logic [EntIdxW-1:0] scan_idx;
  assign issue    = cmd_i.scan_run && (scan_cnt_q < total_q);
  assign scan_idx = scan_cnt_q[EntIdxW-1:0];

  // Distance of the entry read this cycle; a sum not yet written reads as zero.
  logic [63:0] old_dist;
  assign old_dist = dv_q[p1_idx_q] ? dist_rd : '0;

  // Absolute difference of feature and stored element.
  logic signed [32:0] diff;
  logic [32:0]        neg_diff;
  logic [31:0]        abs_diff;
  assign diff     = $signed({cur_feat_q[31], cur_feat_q}) - $signed({vec_rd[31], vec_rd});
  assign neg_diff = -diff;
  assign abs_diff = diff[32] ? neg_diff[31:0] : diff[31:0];

  // Saturating accumulate.
  logic [64:0] acc_sum;
  logic [63:0] dist_wdata;
  logic        dist_we;
  assign acc_sum    = {1'b0, b_old_q} + {1'b0, b_prod_q};
  assign dist_wdata = acc_sum[64] ? '1 : acc_sum[63:0];
  assign dist_we    = b_vld_q && b_en_q;

  // Selection compare.
  logic sel_upd;
  assign sel_upd = p1_q && !scan_query_q && !picked_q[p1_idx_q] &&
                   (!best_vld_q || (old_dist < best_dist_q));

  // Neighbor count limit.
  logic [31:0] k_wide;
  always_comb begin
    k_wide = 32'(nl_q);
    if (k_wide > MAX_K) begin
      k_wide = MAX_K;
    end
    if (k_wide > 32'(total_q)) begin
      k_wide = 32'(total_q);
    end
  end

  // Restoring divider step.
  logic [KW:0]   rem_sh, rem_sub;
  logic          div_ge, div_done;
  assign rem_sh   = {rem_q, quo_q[SumW-1]};
  assign div_ge   = (rem_sh >= {1'b0, count_q});
  assign rem_sub  = rem_sh - {1'b0, count_q};
  assign div_done = (div_cnt_q == DivCntW'(SumW));

  // Signed quotient, truncated toward zero.
  logic [SumW-1:0] quo_neg;
  logic [31:0]     mean;
  assign quo_neg = -quo_q;
  assign mean    = (count_q == '0) ? '0 : (neg_q ? quo_neg[31:0] : quo_q[31:0]);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q         <= NlReset;
      dl_q         <= DlReset;
      pos_q        <= '0;
      total_q      <= '0;
      cur_last_q   <= 1'b0;
      dv_q         <= '0;
      picked_q     <= '0;
      scan_cnt_q   <= '0;
      scan_query_q <= 1'b0;
      p1_q         <= 1'b0;
      a_vld_q      <= 1'b0;
      b_vld_q      <= 1'b0;
      best_vld_q   <= 1'b0;
      k_q          <= '0;
      count_q      <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgNeighborLimit) begin
          nl_q <= cfg_data_i[NlW-1:0];
        end else begin
          dl_q <= cfg_data_i;
        end
      end
      // Element bookkeeping on each accepted transaction.
      if (cmd_i.accept) begin
        cur_last_q <= in_item_i.is_last;
        pos_q      <= in_item_i.is_last ? '0 : pos_after;
        if (pos_q == '0) begin
          dv_q <= '0;
        end
      end
      if (acc_ins_last && !table_full) begin
        total_q <= total_q + 1'b1;
      end
      if (dist_we) begin
        dv_q[b_idx_q] <= 1'b1;
      end
      // Scan counter and pipeline valids.
      if (cmd_i.scan_clr) begin
        scan_cnt_q   <= '0;
        scan_query_q <= cmd_i.scan_query;
        best_vld_q   <= 1'b0;
      end else if (issue) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      p1_q    <= issue;
      a_vld_q <= p1_q && scan_query_q;
      b_vld_q <= a_vld_q;
      if (sel_upd) begin
        best_vld_q <= 1'b1;
      end
      // Selection rounds.
      if (cmd_i.sel_init) begin
        k_q      <= k_wide[KW-1:0];
        count_q  <= '0;
        picked_q <= '0;
      end
      if (cmd_i.sel_take) begin
        picked_q[best_idx_q] <= 1'b1;
        count_q              <= count_q + 1'b1;
      end
      // Divider counter.
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_run && !div_done) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      // Output register valid.
      if (acc_ins_last || cmd_i.out_load_query) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    lim_sq_q <= dl_q * dl_q;
    if (cmd_i.accept) begin
      cur_feat_q <= in_item_i.feature_value;
      cur_pos_q  <= pos_q;
    end
    // Distance pipeline: difference, square, accumulate.
    p1_idx_q <= scan_idx;
    a_abs_q  <= abs_diff;
    a_old_q  <= old_dist;
    a_en_q   <= (cur_pos_q < len_rd);
    a_idx_q  <= p1_idx_q;
    b_prod_q <= a_abs_q * a_abs_q;
    b_old_q  <= a_old_q;
    b_en_q   <= a_en_q;
    b_idx_q  <= a_idx_q;
    // Running minimum.
    if (sel_upd) begin
      best_dist_q <= old_dist;
      best_idx_q  <= p1_idx_q;
    end
    // Target sum.
    if (cmd_i.sel_init) begin
      sum_q <= '0;
    end else if (cmd_i.sel_add) begin
      sum_q <= sum_q + SumW'($signed(tgt_rd));
    end
    // Divider datapath.
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SumW-1];
      quo_q <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
      rem_q <= '0;
    end else if (cmd_i.div_run && !div_done) begin
      quo_q <= {quo_q[SumW-2:0], div_ge};
      rem_q <= div_ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
    end
    // Output payload.
    if (acc_ins_last) begin
      out_item_q.is_query_result <= 1'b0;
      out_item_q.prediction      <= '0;
      out_item_q.neighbors_used  <= '0;
      out_item_q.insert_dropped  <= table_full;
      out_item_q.table_size      <= 7'(total_next);
    end else if (cmd_i.out_load_query) begin
      out_item_q.is_query_result <= 1'b1;
      out_item_q.prediction      <= mean;
      out_item_q.neighbors_used  <= 5'(count_q);
      out_item_q.insert_dropped  <= 1'b0;
      out_item_q.table_size      <= 7'(total_q);
    end
  end

  // Stored vector elements.
  knnrc_ram #(.Width(32), .Depth(VecDepth)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i ({total_q[EntIdxW-1:0], pos_q[DimIdxW-1:0]}),
    .wdata_i (in_item_i.feature_value),
    .raddr_i ({scan_idx, cur_pos_q[DimIdxW-1:0]}),
    .rdata_o (vec_rd)
  );

  // Stored vector lengths.
  knnrc_ram #(.Width(PosW), .Depth(ENTRIES)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (acc_ins_last && !table_full),
    .waddr_i (total_q[EntIdxW-1:0]),
    .wdata_i (pos_after),
    .raddr_i (scan_idx),
    .rdata_o (len_rd)
  );

  // Stored targets.
  knnrc_ram #(.Width(32), .Depth(ENTRIES)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (acc_ins_last && !table_full),
    .waddr_i (total_q[EntIdxW-1:0]),
    .wdata_i (in_item_i.target_value),
    .raddr_i (best_idx_q),
    .rdata_o (tgt_rd)
  );

  // Per-entry squared distance sums.
  knnrc_ram #(.Width(64), .Depth(ENTRIES)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (b_idx_q),
    .wdata_i (dist_wdata),
    .raddr_i (scan_idx),
    .rdata_o (dist_rd)
  );

  // Status to the controller.
  assign status_o.scan_needed = pos_lt_dim && (total_q != '0);
  assign status_o.scan_done   = (scan_cnt_q == total_q) && !p1_q && !a_vld_q && !b_vld_q;
  assign status_o.item_last   = cur_last_q;
  assign status_o.k_zero      = (k_wide == 32'd0);
  assign status_o.k_reached   = (count_q == k_q);
  assign status_o.sel_stop    = (best_dist_q > {2'b00, lim_sq_q});
  assign status_o.div_done    = div_done;
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/knn_regression_with_cutoff.sv */
// An insert element is stored without leaving the idle state. A query element scans the N
// stored entries, one distance memory access per entry. Query end adds up to k rounds
// (one memory scan per neighbor) and a bit-serial division (38 steps).
// Reset (asynchronous, active low) empties the table, clears the element position,
// and loads neighbor_limit 5 and distance_limit 3277; no clearing pass is needed.
// Top level: joins knnrc_ctrl and knnrc_dp; depends on knnrc_pkg.
module knn_regression_with_cutoff import knnrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DlW-1:0]     cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  knnrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Tables and arithmetic.
  knnrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/knnrc_checker.sv */
// Port-level assertions for the nearest-neighbor block, bound to the top level.
// Depends on knnrc_pkg.
module knnrc_checker import knnrc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_item_i
);

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // Insert acknowledgements carry no prediction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.is_query_result |->
      out_item_i.prediction == '0 && out_item_i.neighbors_used == '0)
    else $error("insert acknowledgement carries a prediction");

  // A dropped insert means a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.insert_dropped |->
      !out_item_i.is_query_result && out_item_i.table_size == 7'(ENTRIES))
    else $error("insert dropped with room in the table");

  // Neighbor count stays within limits and table occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.table_size <= 7'(ENTRIES) &&
      out_item_i.neighbors_used <= 5'(MAX_K) &&
      7'(out_item_i.neighbors_used) <= out_item_i.table_size)
    else $error("neighbor count out of range");

  // No neighbors means a zero prediction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.neighbors_used == '0 |-> out_item_i.prediction == '0)
    else $error("prediction without neighbors");

endmodule

bind knn_regression_with_cutoff knnrc_checker u_knnrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);
